### rtl/core/hpj_pkg.sv
package hpj_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_SHIMMER_SHIFT = 3'd2;
  localparam logic [2:0] REG_AMOUNT_Q8     = 3'd3;
  localparam logic [2:0] REG_MIX_Q8        = 3'd4;
  localparam logic [2:0] REG_DIRECTION     = 3'd5;
  localparam logic [2:0] REG_HASH_SEED     = 3'd6;
  localparam logic [2:0] REG_CHROMA_MODE   = 3'd7;

  // Direction codes
  localparam logic [1:0] DIR_HORIZ = 2'd0;
  localparam logic [1:0] DIR_VERT  = 2'd1;
  localparam logic [1:0] DIR_BOTH  = 2'd2;

  // Register reset values
  localparam logic [9:0]  RST_FRAME_WIDTH   = 10'd512;
  localparam logic [9:0]  RST_FRAME_HEIGHT  = 10'd512;
  localparam logic [4:0]  RST_SHIMMER_SHIFT = 5'd12;
  localparam logic [10:0] RST_AMOUNT_Q8     = 11'd256;
  localparam logic [8:0]  RST_MIX_Q8        = 9'd256;
  localparam logic [1:0]  RST_DIRECTION     = DIR_BOTH;
  localparam logic [31:0] RST_HASH_SEED     = 32'h1337_BEEF;
  localparam logic        RST_CHROMA_MODE   = 1'b0;

  localparam int FRAME_DIM_W = 10;

  // Hash and offset constants
  localparam logic [31:0] HASH_MUL1       = 32'h7feb352d;
  localparam logic [31:0] HASH_MUL2       = 32'h846ca68b;
  localparam logic [4:0]  HASH_BASE_SHIFT = 5'd10;
  localparam logic [4:0]  SHIFT_MAX       = 5'd17;
  localparam logic [4:0]  YSTEP_CHROMA    = 5'd2;
  localparam logic [4:0]  YSTEP_LUMA      = 5'd3;
  localparam logic [2:0]  OFS_MASK_CHROMA = 3'h3;
  localparam logic [2:0]  OFS_MASK_LUMA   = 3'h7;
  localparam logic [2:0]  BIAS_CHROMA     = 3'd1;
  localparam logic [2:0]  BIAS_LUMA       = 3'd3;
  localparam logic [10:0] AMT_MAX         = 11'd1024;
  localparam logic [8:0]  MIX_MAX         = 9'd256;
  localparam logic [8:0]  Q8_ONE          = 9'd256;
  localparam logic [7:0]  Q8_HALF         = 8'd128;

  localparam int QUEUE_DEPTH = 4;

  // Effective (saturated) settings seen by the processing pipeline
  typedef struct packed {
    logic [31:0] seed;
    logic [4:0]  xshift;
    logic [4:0]  yshift;
    logic        chroma;
    logic        mx;
    logic        my;
    logic [10:0] amt;
    logic [8:0]  mix;
  } hpj_cfg_t;

endpackage

### rtl/core/hashed_pixel_jitter_displace.sv
// Hashed pixel jitter: streams one 8-bit plane in raster order and returns,
// for each position, a sample of the previous frame displaced by a hashed
// offset and mixed with the undisplaced sample.
// Input channel (in_valid / in_stall / in_pixel_in): one request per pixel.
// Result channel (out_valid / out_stall / out_pixel_out, out_end_of_frame):
// exactly one result per request, in order; end_of_frame marks the last
// pixel of a frame.
// Throughput: one pixel per clock sustained unless out_stall holds or the
// store is clearing. Requests pass through the index multiply, two hash
// multiplies, offset, clamp, source multiply, store read and blend stages.
// A 4-entry queue sits between the counter front and the pipeline, so
// requests keep flowing while a result waits; when out_stall holds, the
// pipeline freezes and in_stall rises once the queue fills.
// Reset: the frame store (2 * 2^clog2(MAX_WIDTH*MAX_HEIGHT) bytes) is
// cleared one byte per cycle, 524288 bytes at the defaults, with in_stall
// high. The configuration port (cfg_valid / cfg_ready / cfg_index /
// cfg_data) is always ready; write it only while no pixel is in flight.
module hashed_pixel_jitter_displace
  import hpj_pkg::*;
#(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_pixel_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_pixel_out,
  output logic        out_end_of_frame,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int LW  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int IW  = CW + LW + 10;
  localparam int WCW = (WW > FRAME_DIM_W) ? WW : FRAME_DIM_W;
  localparam int HCW = (HW > FRAME_DIM_W) ? HW : FRAME_DIM_W;

  logic [9:0]  frame_width_r;
  logic [9:0]  frame_height_r;
  logic [4:0]  shimmer_shift_r;
  logic [10:0] amount_q8_r;
  logic [8:0]  mix_q8_r;
  logic [1:0]  direction_r;
  logic [31:0] hash_seed_r;
  logic        chroma_mode_r;

  logic [WCW-1:0] fw, w_sat;
  logic [HCW-1:0] fh, h_sat;
  logic [WW-1:0]  w_eff;
  logic [HW-1:0]  h_eff;
  logic [4:0]     sh_sat;
  hpj_cfg_t       cfg;

  logic          push, pop, fifo_empty, fifo_full, clearing;
  logic [IW-1:0] item_w, item_r;

  assign cfg_ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= RST_FRAME_WIDTH;
      frame_height_r  <= RST_FRAME_HEIGHT;
      shimmer_shift_r <= RST_SHIMMER_SHIFT;
      amount_q8_r     <= RST_AMOUNT_Q8;
      mix_q8_r        <= RST_MIX_Q8;
      direction_r     <= RST_DIRECTION;
      hash_seed_r     <= RST_HASH_SEED;
      chroma_mode_r   <= RST_CHROMA_MODE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:   frame_width_r   <= cfg_data[9:0];
        REG_FRAME_HEIGHT:  frame_height_r  <= cfg_data[9:0];
        REG_SHIMMER_SHIFT: shimmer_shift_r <= cfg_data[4:0];
        REG_AMOUNT_Q8:     amount_q8_r     <= cfg_data[10:0];
        REG_MIX_Q8:        mix_q8_r        <= cfg_data[8:0];
        REG_DIRECTION:     direction_r     <= cfg_data[1:0];
        REG_HASH_SEED:     hash_seed_r     <= cfg_data;
        REG_CHROMA_MODE:   chroma_mode_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Saturate settings to their working ranges
  always_comb begin
    fw = WCW'(frame_width_r);
    if (fw == '0) begin
      w_sat = WCW'(1);
    end else if (fw > WCW'(MAX_WIDTH)) begin
      w_sat = WCW'(MAX_WIDTH);
    end else begin
      w_sat = fw;
    end
    fh = HCW'(frame_height_r);
    if (fh == '0) begin
      h_sat = HCW'(1);
    end else if (fh > HCW'(MAX_HEIGHT)) begin
      h_sat = HCW'(MAX_HEIGHT);
    end else begin
      h_sat = fh;
    end
    w_eff = WW'(w_sat);
    h_eff = HW'(h_sat);

    sh_sat     = (shimmer_shift_r > SHIFT_MAX) ? SHIFT_MAX : shimmer_shift_r;
    cfg.seed   = hash_seed_r;
    cfg.xshift = HASH_BASE_SHIFT + sh_sat;
    cfg.yshift = HASH_BASE_SHIFT + sh_sat + (chroma_mode_r ? YSTEP_CHROMA : YSTEP_LUMA);
    cfg.chroma = chroma_mode_r;
    cfg.mx     = (direction_r == DIR_HORIZ) || (direction_r == DIR_BOTH);
    cfg.my     = (direction_r == DIR_VERT) || (direction_r == DIR_BOTH);
    cfg.amt    = (amount_q8_r > AMT_MAX) ? AMT_MAX : amount_q8_r;
    cfg.mix    = (mix_q8_r > MIX_MAX) ? MIX_MAX : mix_q8_r;
  end

  hpj_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_pixel    (in_pixel_in),
    .clearing_i  (clearing),
    .fifo_full_i (fifo_full),
    .w_i         (w_eff),
    .h_i         (h_eff),
    .push_o      (push),
    .item_o      (item_w)
  );

  hpj_fifo #(
    .W     (IW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .din_i   (item_w),
    .pop_i   (pop),
    .dout_o  (item_r),
    .empty_o (fifo_empty),
    .full_o  (fifo_full)
  );

  hpj_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_i        (cfg),
    .w_i          (w_eff),
    .h_i          (h_eff),
    .item_i       (item_r),
    .fifo_empty_i (fifo_empty),
    .pop_o        (pop),
    .clearing_o   (clearing),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_pixel_o  (out_pixel_out),
    .out_eof_o    (out_end_of_frame)
  );

endmodule

### rtl/core/hpj_front.sv
module hpj_front #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           in_pixel,
  input  logic                                 clearing_i,
  input  logic                                 fifo_full_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]       w_i,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]      h_i,
  output logic                                 push_o,
  output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)+9:0] item_o
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int LW  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int CXW = ((CW > WW) ? CW : WW) + 1;
  localparam int LXW = ((LW > HW) ? LW : HW) + 1;

  logic          acc;
  logic [CW-1:0] col_r, col_nxt, colf;
  logic [LW-1:0] line_r, line_nxt, linef;
  logic          bank_r, bank_nxt;
  logic [CXW-1:0] col_inc;
  logic [LXW-1:0] line_inc;
  logic          col_wrap, line_wrap;

  // Take a request whenever the queue has room and the store is ready
  assign in_stall = clearing_i || fifo_full_i;
  assign acc      = in_valid && !in_stall;
  assign push_o   = acc;

  // Restart counters beyond a shrunk size, then step the raster position
  always_comb begin
    colf      = (CXW'(col_r) >= CXW'(w_i)) ? '0 : col_r;
    linef     = (LXW'(line_r) >= LXW'(h_i)) ? '0 : line_r;
    col_inc   = CXW'(colf) + CXW'(1);
    line_inc  = LXW'(linef) + LXW'(1);
    col_wrap  = col_inc >= CXW'(w_i);
    line_wrap = col_wrap && (line_inc >= LXW'(h_i));
    col_nxt   = col_wrap ? '0 : col_inc[CW-1:0];
    if (col_wrap) begin
      line_nxt = line_wrap ? '0 : line_inc[LW-1:0];
    end else begin
      line_nxt = linef;
    end
    bank_nxt = bank_r ^ line_wrap;
  end

  // Tag the request with its position, bank and frame end
  assign item_o = {in_pixel, bank_r, line_wrap, linef, colf};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      line_r <= '0;
      bank_r <= 1'b0;
    end else if (acc) begin
      col_r  <= col_nxt;
      line_r <= line_nxt;
      bank_r <= bank_nxt;
    end
  end

`ifndef SYNTHESIS
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> (CXW'(col_r) < CXW'(w_i)) && (LXW'(line_r) < LXW'(h_i)))
    else $error("raster position left the frame after a request");
  a_bank_flip: assert property (@(posedge clk) disable iff (!rst_n)
    acc && line_wrap |=> bank_r != $past(bank_r))
    else $error("bank did not flip at frame end");
`endif

endmodule

### rtl/core/hpj_fifo.sv
module hpj_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_i,
  input  logic [W-1:0] din_i,
  input  logic         pop_i,
  output logic [W-1:0] dout_o,
  output logic         empty_o,
  output logic         full_o
);

  localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  logic [W-1:0]   q_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNW-1:0] count_r;

  assign dout_o  = q_r[rd_ptr_r];
  assign empty_o = (count_r == '0);
  assign full_o  = (count_r == CNW'(DEPTH));

  // Store entries
  always_ff @(posedge clk) begin
    if (push_i) begin
      q_r[wr_ptr_r] <= din_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push_i && !pop_i) begin
        count_r <= count_r + CNW'(1);
      end else if (pop_i && !push_i) begin
        count_r <= count_r - CNW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (push_i && full_o |-> pop_i) and (pop_i |-> !empty_o))
    else $error("queue overrun or underrun");
`endif

endmodule

### rtl/core/hpj_back.sv
module hpj_back
  import hpj_pkg::*;
#(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  hpj_cfg_t                             cfg_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]       w_i,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]      h_i,
  input  logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)+9:0] item_i,
  input  logic                                 fifo_empty_i,
  output logic                                 pop_o,
  output logic                                 clearing_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [7:0]                           out_pixel_o,
  output logic                                 out_eof_o
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int LW   = $clog2(MAX_HEIGHT);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int AW   = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int MAW  = AW + 1;
  localparam int MEM_DEPTH = 2 ** MAW;
  localparam int PRW  = LW + WW;
  localparam int SXW  = CW + 2;
  localparam int SYW  = LW + 2;
  localparam int SDW  = 10;
  localparam int NST  = 6;

  // Pixel offset for one axis: field from the hash, bias, Q8 scale with
  // symmetric rounding
  function automatic logic signed [5:0] axis_offset(
    input logic [31:0] r,
    input logic [4:0]  sh,
    input logic        chroma,
    input logic        en,
    input logic [10:0] amt
  );
    logic [31:0]       t;
    logic [2:0]        f;
    logic [2:0]        bias;
    logic signed [3:0] v;
    logic [2:0]        mag;
    logic [13:0]       sc;
    logic [5:0]        m;
    t    = r >> sh;
    f    = t[2:0] & (chroma ? OFS_MASK_CHROMA : OFS_MASK_LUMA);
    bias = chroma ? BIAS_CHROMA : BIAS_LUMA;
    v    = en ? ($signed({1'b0, f}) - $signed({1'b0, bias})) : 4'sd0;
    mag  = v[3] ? 3'(-v) : v[2:0];
    sc   = 14'(mag) * 14'(amt) + 14'(Q8_HALF);
    m    = sc[13:8];
    return v[3] ? -$signed(m) : $signed(m);
  endfunction

  logic [7:0] mem [MEM_DEPTH];

  logic        adv;
  logic [NST:0] v_r;
  logic        out_valid_r;
  logic [7:0]  out_pix_r;
  logic        out_eof_r;
  logic        clear_active_r;
  logic [MAW-1:0] clr_addr_r;

  // Sideband {pixel, bank, eof} and index ride along stages 1..6
  logic [SDW-1:0] side_r [1:NST];
  logic [AW-1:0]  idx_r  [1:NST];
  logic [CW-1:0]  col_r  [1:4];
  logic [LW-1:0]  line_r [1:4];
  logic [31:0]    p1_r, p2_r;
  logic signed [5:0] dx_r, dy_r;
  logic [CW-1:0]  sx_r;
  logic [LW-1:0]  sy_r;
  logic [AW-1:0]  src_r;
  logic [7:0]     rda_r, rdb_r;
  logic           eof7_r;

  logic [CW-1:0]  col_in;
  logic [LW-1:0]  line_in;
  logic [SDW-1:0] side_in;
  logic [PRW-1:0] prod1, prod6;
  logic [AW-1:0]  idx_nxt, src_nxt;
  logic [31:0]    h0, h1, h2, r4;
  logic [31:0]    p1_nxt, p2_nxt;
  logic signed [5:0] dx_nxt, dy_nxt;
  logic signed [SXW-1:0] sxs, wlim;
  logic signed [SYW-1:0] sys, hlim;
  logic [CW-1:0]  sx_nxt;
  logic [LW-1:0]  sy_nxt;
  logic           bank6;
  logic           mem_we;
  logic [MAW-1:0] mem_wa;
  logic [7:0]     mem_wd;
  logic [8:0]     mix_n;
  logic [17:0]    blend;

  // Whole pipeline moves unless the result register is held
  assign adv         = !out_valid_r || !out_stall_i;
  assign pop_o       = adv && !fifo_empty_i && !clear_active_r;
  assign clearing_o  = clear_active_r;
  assign out_valid_o = out_valid_r;
  assign out_pixel_o = out_pix_r;
  assign out_eof_o   = out_eof_r;

  // Unpack the queued request
  assign col_in  = item_i[CW-1:0];
  assign line_in = item_i[CW +: LW];
  assign side_in = item_i[CW+LW +: SDW];

  always_comb begin
    // Stage 1: linear pixel index
    prod1   = {{WW{1'b0}}, line_in} * {{LW{1'b0}}, w_i};
    idx_nxt = AW'(prod1 + PRW'(col_in));
    // Stages 2 and 3: hash rounds, one multiply each
    h0      = 32'(idx_r[1]) ^ cfg_i.seed;
    h1      = h0 ^ (h0 >> 16);
    p1_nxt  = h1 * HASH_MUL1;
    h2      = p1_r ^ (p1_r >> 15);
    p2_nxt  = h2 * HASH_MUL2;
    // Stage 4: offsets from the hash
    r4      = p2_r ^ (p2_r >> 16);
    dx_nxt  = axis_offset(r4, cfg_i.xshift, cfg_i.chroma, cfg_i.mx, cfg_i.amt);
    dy_nxt  = axis_offset(r4, cfg_i.yshift, cfg_i.chroma, cfg_i.my, cfg_i.amt);
    // Stage 5: clamp source coordinates to the frame
    sxs     = $signed({2'b00, col_r[4]}) + SXW'(dx_r);
    sys     = $signed({2'b00, line_r[4]}) + SYW'(dy_r);
    wlim    = $signed(SXW'(w_i) - SXW'(1));
    hlim    = $signed(SYW'(h_i) - SYW'(1));
    if (sxs[SXW-1]) begin
      sx_nxt = '0;
    end else if (sxs > wlim) begin
      sx_nxt = wlim[CW-1:0];
    end else begin
      sx_nxt = sxs[CW-1:0];
    end
    if (sys[SYW-1]) begin
      sy_nxt = '0;
    end else if (sys > hlim) begin
      sy_nxt = hlim[LW-1:0];
    end else begin
      sy_nxt = sys[LW-1:0];
    end
    // Stage 6: source index
    prod6   = {{WW{1'b0}}, sy_r} * {{LW{1'b0}}, w_i};
    src_nxt = AW'(prod6 + PRW'(sx_r));
    // Stage 7: store write port, shared with the clearing sweep
    bank6   = side_r[NST][1];
    mem_we  = clear_active_r || (adv && v_r[NST-1]);
    mem_wa  = clear_active_r ? clr_addr_r : {bank6, idx_r[NST]};
    mem_wd  = clear_active_r ? 8'd0 : side_r[NST][SDW-1:2];
    // Output stage: Q8 blend of same-position and displaced samples
    mix_n   = Q8_ONE - cfg_i.mix;
    blend   = 18'(rda_r) * 18'(mix_n) + 18'(rdb_r) * 18'(cfg_i.mix) + 18'(Q8_HALF);
  end

  // Frame store: one write, two registered reads from the other bank
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (adv) begin
      rda_r <= mem[{~bank6, idx_r[NST]}];
      rdb_r <= mem[{~bank6, src_r}];
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[1] <= side_in;
      idx_r[1]  <= idx_nxt;
      col_r[1]  <= col_in;
      line_r[1] <= line_in;
      for (int i = 2; i <= NST; i++) begin
        side_r[i] <= side_r[i-1];
        idx_r[i]  <= idx_r[i-1];
      end
      for (int i = 2; i <= 4; i++) begin
        col_r[i]  <= col_r[i-1];
        line_r[i] <= line_r[i-1];
      end
      p1_r      <= p1_nxt;
      p2_r      <= p2_nxt;
      dx_r      <= dx_nxt;
      dy_r      <= dy_nxt;
      sx_r      <= sx_nxt;
      sy_r      <= sy_nxt;
      src_r     <= src_nxt;
      eof7_r    <= side_r[NST][0];
      out_pix_r <= blend[15:8];
      out_eof_r <= eof7_r;
    end
  end

  // Valid chain, result register and clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r            <= '0;
      out_valid_r    <= 1'b0;
      clear_active_r <= 1'b1;
      clr_addr_r     <= '0;
    end else begin
      if (adv) begin
        v_r         <= {v_r[NST-1:0], pop_o};
        out_valid_r <= v_r[NST];
      end
      if (clear_active_r) begin
        clr_addr_r <= clr_addr_r + MAW'(1);
        if (clr_addr_r == '1) begin
          clear_active_r <= 1'b0;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_idle_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clear_active_r |-> (v_r == '0) && !out_valid_r)
    else $error("request in flight during store clearing");
  a_clear_complete: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clear_active_r) |-> $past(clr_addr_r) == '1)
    else $error("store clearing ended early");
`endif

endmodule

### tb/tb_hashed_pixel_jitter_displace.sv
`timescale 1ns / 1ps

module tb_hashed_pixel_jitter_displace;
  import hpj_pkg::*;

  localparam int MAX_W = 512;
  localparam int MAX_H = 512;
  localparam int PLANE_SIZE = MAX_W * MAX_H;
  localparam int LATENCY_PAD = 12;
  localparam int MAX_REPORTS = 40;
  // Neither axis enabled
  localparam logic [1:0] DIR_NONE = 2'd3;

  typedef struct {
    logic [7:0] pixel;
    logic       eof;
  } pixel_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_pixel_in;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_pixel_out;
  logic        out_end_of_frame;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  // Shadow copy of the register file
  logic [9:0]  cfg_width  = RST_FRAME_WIDTH;
  logic [9:0]  cfg_height = RST_FRAME_HEIGHT;
  logic [4:0]  cfg_shift  = RST_SHIMMER_SHIFT;
  logic [10:0] cfg_amount = RST_AMOUNT_Q8;
  logic [8:0]  cfg_mix    = RST_MIX_Q8;
  logic [1:0]  cfg_dir    = RST_DIRECTION;
  logic [31:0] cfg_seed   = RST_HASH_SEED;
  logic        cfg_chroma = RST_CHROMA_MODE;

  // Shadow raster position, bank and both frame banks
  int col_pos = 0;
  int line_pos = 0;
  bit write_bank = 1'b0;
  bit [7:0] plane_banks [0:2*PLANE_SIZE-1];

  pixel_result_t expected_pixels[$];
  int error_count = 0;
  bit idle_on = 1'b1;

  hashed_pixel_jitter_displace dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel_in      (in_pixel_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_out    (out_pixel_out),
    .out_end_of_frame (out_end_of_frame),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #10 clk = ~clk;

  task automatic report_error(input string msg);
    if (error_count < MAX_REPORTS) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
    error_count++;
  endtask

  // Mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned pick_corner(input int unsigned lo, hi, top);
    int roll;
    roll = $urandom_range(0, 3);
    if (roll == 0) return lo;
    if (roll == 1) return hi;
    return $urandom_range(0, top);
  endfunction

  function automatic logic [31:0] scramble32(input logic [31:0] v);
    logic [31:0] t;
    t = v ^ (v >> 16);
    t = t * HASH_MUL1;
    t = t ^ (t >> 15);
    t = t * HASH_MUL2;
    t = t ^ (t >> 16);
    return t;
  endfunction

  // Q8 scale with rounding away from zero on the half
  function automatic int scale_offset(input int v, input int q);
    if (v >= 0) return (v * q + 128) >>> 8;
    return -(((-v) * q + 128) >>> 8);
  endfunction

  function automatic int clamp_coord(input int v, input int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // Compute the displaced, mixed sample for one request and update the shadow state
  task automatic predict_pixel(input logic [7:0] px, output pixel_result_t res);
    int w, h, sh, shift, yshift, mask, bias, mx, my, amt, q;
    int idx, dx, dy, sx, sy, wr, rd, a, b;
    logic [31:0] r;
    w = int'(cfg_width);
    h = int'(cfg_height);
    if (w < 1) w = 1;
    if (w > MAX_W) w = MAX_W;
    if (h < 1) h = 1;
    if (h > MAX_H) h = MAX_H;
    // restart counters that fall outside a shrunk frame
    if (col_pos >= w) col_pos = 0;
    if (line_pos >= h) line_pos = 0;

    sh = (cfg_shift > 17) ? 17 : int'(cfg_shift);
    shift = 10 + sh;
    mask = cfg_chroma ? 3 : 7;
    bias = cfg_chroma ? 1 : 3;
    yshift = shift + (cfg_chroma ? 2 : 3);
    mx = (cfg_dir == DIR_HORIZ || cfg_dir == DIR_BOTH) ? 1 : 0;
    my = (cfg_dir == DIR_VERT || cfg_dir == DIR_BOTH) ? 1 : 0;
    amt = (cfg_amount > 1024) ? 1024 : int'(cfg_amount);
    q = (cfg_mix > 256) ? 256 : int'(cfg_mix);

    idx = line_pos * w + col_pos;
    r = scramble32(32'(idx) ^ cfg_seed);
    dx = scale_offset((int'((r >> shift) & 32'(mask)) - bias) * mx, amt);
    dy = scale_offset((int'((r >> yshift) & 32'(mask)) - bias) * my, amt);
    sx = clamp_coord(col_pos + dx, w - 1);
    sy = clamp_coord(line_pos + dy, h - 1);

    wr = write_bank ? PLANE_SIZE : 0;
    rd = write_bank ? 0 : PLANE_SIZE;
    a = plane_banks[rd + idx];
    b = plane_banks[rd + sy * w + sx];
    res.pixel = 8'((a * (256 - q) + b * q + 128) >> 8);
    plane_banks[wr + idx] = px;

    // advance the raster position, flip banks at end of frame
    res.eof = 1'b0;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      line_pos++;
      if (line_pos >= h) begin
        line_pos = 0;
        write_bank = ~write_bank;
        res.eof = 1'b1;
      end
    end
  endtask

  // Send one request, with a random gap ahead of it while idle_on is set
  task automatic send_pixel(input logic [7:0] px);
    int gap;
    logic taken;
    pixel_result_t res;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_in <= px;
    do begin
      @(negedge clk);
      taken = (in_stall === 1'b0);
      @(posedge clk);
    end while (!taken);
    predict_pixel(px, res);
    expected_pixels.push_back(res);
  endtask

  // Write one register; leave cfg_valid high for a following write
  task automatic write_reg(input logic [2:0] index, input logic [31:0] value,
                           input logic [31:0] mask);
    logic taken;
    logic [31:0] data;
    data = ($urandom & ~mask) | (value & mask);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do begin
      @(negedge clk);
      taken = (cfg_ready === 1'b1);
      @(posedge clk);
    end while (!taken);
    case (index)
      REG_FRAME_WIDTH:   cfg_width  = data[9:0];
      REG_FRAME_HEIGHT:  cfg_height = data[9:0];
      REG_SHIMMER_SHIFT: cfg_shift  = data[4:0];
      REG_AMOUNT_Q8:     cfg_amount = data[10:0];
      REG_MIX_Q8:        cfg_mix    = data[8:0];
      REG_DIRECTION:     cfg_dir    = data[1:0];
      REG_HASH_SEED:     cfg_seed   = data;
      REG_CHROMA_MODE:   cfg_chroma = data[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int unsigned w, h, shift, amount, mix, dir,
                            input logic [31:0] seed, input int unsigned chroma);
    write_reg(REG_FRAME_WIDTH, w, 32'h3FF);
    write_reg(REG_FRAME_HEIGHT, h, 32'h3FF);
    write_reg(REG_SHIMMER_SHIFT, shift, 32'h1F);
    write_reg(REG_AMOUNT_Q8, amount, 32'h7FF);
    write_reg(REG_MIX_Q8, mix, 32'h1FF);
    write_reg(REG_DIRECTION, dir, 32'h3);
    write_reg(REG_HASH_SEED, seed, 32'hFFFF_FFFF);
    write_reg(REG_CHROMA_MODE, chroma, 32'h1);
    cfg_valid <= 1'b0;
  endtask

  // Hold off new requests until every result is back, then let the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY_PAD) @(posedge clk);
  endtask

  // First frame reads as zero; the second blends samples of the first frame
  task automatic test_first_frame();
    logic [7:0] pattern [6];
    pattern = '{8'h00, 8'hFF, 8'hAA, 8'h55, 8'h01, 8'h80};
    idle_on = 1'b1;
    wait_idle();
    set_config(3, 2, 12, 256, 256, DIR_NONE, $urandom, 0);
    foreach (pattern[i]) send_pixel(pattern[i]);
    wait_idle();
    set_config(3, 2, 0, 1024, 128, DIR_BOTH, $urandom, 0);
    foreach (pattern[i]) send_pixel(~pattern[i]);
    wait_idle();
  endtask

  // Zero sizes, oversized sizes and saturating shift, amount and mix
  task automatic test_saturated_registers();
    wait_idle();
    set_config(0, 0, 31, 2047, 511, DIR_NONE, 32'hFFFF_FFFF, 1);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    wait_idle();
    set_config(1023, 1023, 17, 1024, 0, DIR_VERT, 32'h0, 1);
    send_pixel(8'h7F);
    send_pixel(8'hFE);
    wait_idle();
  endtask

  // Shrink the width mid-frame so the column count restarts without a bank flip
  task automatic test_counter_restart();
    wait_idle();
    set_config(4, 3, 0, 1024, 256, DIR_HORIZ, $urandom, 0);
    repeat (5) send_pixel($urandom_range(0, 255));
    wait_idle();
    set_config(1, 3, 0, 1024, 256, DIR_HORIZ, $urandom, 0);
    repeat (3) send_pixel($urandom_range(0, 255));
    wait_idle();
  endtask

  // Random settings per phase; two phases hit the widest and tallest frames
  task automatic test_random_phases();
    int unsigned w, h, n, shift, amount, mix, dir, chroma;
    logic [31:0] seed;
    for (int phase = 0; phase < 12; phase++) begin
      if (phase == 3) begin
        w = $urandom_range(0, 1) ? 512 : 1023;
        h = 1;
        n = 515;
      end else if (phase == 7) begin
        w = 1;
        h = $urandom_range(0, 1) ? 512 : 700;
        n = 515;
      end else begin
        w = $urandom_range(0, 16);
        h = $urandom_range(0, 8);
        n = $urandom_range(20, 60);
      end
      shift = pick_corner(0, 17, 31);
      amount = pick_corner(0, 1024, 2047);
      mix = pick_corner(0, 256, 511);
      dir = $urandom_range(0, 3);
      chroma = $urandom_range(0, 1);
      case ($urandom_range(0, 3))
        0: seed = 32'h0;
        1: seed = 32'hFFFF_FFFF;
        default: seed = $urandom;
      endcase
      wait_idle();
      idle_on = ($urandom_range(0, 3) != 0);
      set_config(w, h, shift, amount, mix, dir, seed, chroma);
      repeat (n) send_pixel($urandom_range(0, 255));
    end
    idle_on = 1'b1;
    wait_idle();
  endtask

  // Sample results before the edge, drive random stalls after it while idle_on is set
  initial begin : result_monitor
    logic got;
    logic [7:0] seen_pixel;
    logic seen_eof;
    pixel_result_t want;
    int stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      got = (rst_n === 1'b1) && (out_valid === 1'b1) && !out_stall;
      seen_pixel = out_pixel_out;
      seen_eof = out_end_of_frame;
      @(posedge clk);
      if (got) begin
        if (expected_pixels.size() == 0) begin
          report_error("result with no request pending");
        end else begin
          want = expected_pixels.pop_front();
          if (seen_pixel !== want.pixel)
            report_error($sformatf("pixel_out got %0d want %0d", seen_pixel, want.pixel));
          if (seen_eof !== want.eof)
            report_error($sformatf("end_of_frame got %0b want %0b", seen_eof, want.eof));
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = idle_on ? pick_gap() : 0;
      end
    end
  end

  // Reset clear of the frame store alone takes about 10.5 ms
  initial begin : run_limit
    #(64'd60_000_000);
    $display("tb: failure");
    $finish;
  end

  initial begin : main_sequence
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_pixel_in <= 8'h00;
    cfg_valid <= 1'b0;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data <= 32'h0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_first_frame();
    test_saturated_registers();
    test_counter_restart();
    test_random_phases();

    wait_idle();
    if (error_count == 0 && expected_pixels.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
